@@ src/afd_pkg.sv @@
// Shared types and constants for the ARMv2 fetch dispatch decision block.
`default_nettype none

package afd_pkg;

    // Field widths
    localparam int unsigned PC_W    = 26;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned FLAGS_W = 4;
    localparam int unsigned VEC_W   = 5;

    // Exception vectors
    localparam logic [VEC_W-1:0] VEC_NONE = 5'h00;
    localparam logic [VEC_W-1:0] VEC_FIQ  = 5'h1c;
    localparam logic [VEC_W-1:0] VEC_IRQ  = 5'h18;

    // Fetch advance per step
    localparam logic [PC_W-1:0] PC_STEP = 26'd4;

    // Processor modes
    typedef enum logic [1:0] {
        USER_MODE = 2'd0,
        FIQ_MODE  = 2'd1,
        IRQ_MODE  = 2'd2,
        SVC_MODE  = 2'd3
    } mode_t;

    // Interrupt mask and pin bit positions
    localparam int unsigned FIQ_BIT = 0;
    localparam int unsigned IRQ_BIT = 1;
    localparam logic [1:0] MASKS_ALL = 2'b11;

    // Fetch-stage outcome
    typedef enum logic [2:0] {
        OUT_WAIT       = 3'd0,
        OUT_FIQ        = 3'd1,
        OUT_IRQ        = 3'd2,
        OUT_PABORT     = 3'd3,
        OUT_BKPT_STOP  = 3'd4,
        OUT_BKPT_SWI   = 3'd5,
        OUT_COND_FAIL  = 3'd6,
        OUT_EXECUTE    = 3'd7
    } outcome_t;

    // Instruction class
    typedef enum logic [3:0] {
        CLS_MUL     = 4'd0,
        CLS_SWAP    = 4'd1,
        CLS_ALU     = 4'd2,
        CLS_LDR_STR = 4'd3,
        CLS_BRANCH  = 4'd4,
        CLS_LDM_STM = 4'd5,
        CLS_SWI     = 4'd6,
        CLS_CP_XFER = 4'd7,
        CLS_CP_REG  = 4'd8,
        CLS_CP_DATA = 4'd9
    } iclass_t;

    // One input item
    typedef struct packed {
        logic [PC_W-1:0]    program_counter;
        logic [WORD_W-1:0]  instruction_word;
        logic [FLAGS_W-1:0] nzcv_flags;
        logic [1:0]         interrupt_masks;
        logic [1:0]         interrupt_pins;
        logic [1:0]         current_mode;
        logic               waiting;
        logic               page_mapped;
        logic               breakpoint_hit;
    } item_t;

    // Decode status handed from the decoder to the decision logic
    typedef struct packed {
        logic    cond_pass;
        iclass_t iclass;
    } decode_t;

    // One result item
    typedef struct packed {
        outcome_t          outcome;
        iclass_t           iclass;
        logic [PC_W-1:0]   fetch_address;
        logic [VEC_W-1:0]  vector_address;
        logic [1:0]        mode_after;
        logic [1:0]        masks_after;
        logic              clear_irq_and_wait;
    } result_t;

endpackage

`default_nettype wire

@@ src/afd_decode.sv @@
// Condition code check and instruction class decode of the fetched word.
`default_nettype none

module afd_decode
    import afd_pkg::*;
(
    input  wire logic [WORD_W-1:0]  instruction_word,
    input  wire logic [FLAGS_W-1:0] nzcv_flags,
    output decode_t                 dec
);

    // Condition field codes
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_CS = 4'h2;
    localparam logic [3:0] COND_CC = 4'h3;
    localparam logic [3:0] COND_MI = 4'h4;
    localparam logic [3:0] COND_PL = 4'h5;
    localparam logic [3:0] COND_VS = 4'h6;
    localparam logic [3:0] COND_VC = 4'h7;
    localparam logic [3:0] COND_HI = 4'h8;
    localparam logic [3:0] COND_LS = 4'h9;
    localparam logic [3:0] COND_GE = 4'ha;
    localparam logic [3:0] COND_LT = 4'hb;
    localparam logic [3:0] COND_GT = 4'hc;
    localparam logic [3:0] COND_LE = 4'hd;
    localparam logic [3:0] COND_AL = 4'he;

    // Major opcode groups, bits 27:26
    localparam logic [1:0] GRP_DATA = 2'd0;
    localparam logic [1:0] GRP_XFER = 2'd1;
    localparam logic [1:0] GRP_BLK  = 2'd2;

    // Pattern masks
    localparam logic [WORD_W-1:0] MUL_MASK  = 32'h0fc000f0;
    localparam logic [WORD_W-1:0] MUL_MATCH = 32'h00000090;
    localparam logic [WORD_W-1:0] SWP_MASK  = 32'h0fb00ff0;
    localparam logic [WORD_W-1:0] SWP_MATCH = 32'h01000090;
    localparam logic [WORD_W-1:0] SWI_MASK  = 32'h0f000000;
    localparam int unsigned       BIT_I     = 25;
    localparam int unsigned       BIT_CPREG = 4;

    logic       n_flag;
    logic       z_flag;
    logic       c_flag;
    logic       v_flag;
    logic [3:0] cond;
    logic       pass;
    iclass_t    cls;

    assign n_flag = nzcv_flags[3];
    assign z_flag = nzcv_flags[2];
    assign c_flag = nzcv_flags[1];
    assign v_flag = nzcv_flags[0];
    assign cond   = instruction_word[31:28];

    // Evaluate the condition field against the flags
    always_comb
    begin
        case (cond)
            COND_EQ: pass = z_flag;
            COND_NE: pass = !z_flag;
            COND_CS: pass = c_flag;
            COND_CC: pass = !c_flag;
            COND_MI: pass = n_flag;
            COND_PL: pass = !n_flag;
            COND_VS: pass = v_flag;
            COND_VC: pass = !v_flag;
            COND_HI: pass = c_flag && !z_flag;
            COND_LS: pass = !c_flag || z_flag;
            COND_GE: pass = (n_flag == v_flag);
            COND_LT: pass = (n_flag != v_flag);
            COND_GT: pass = !z_flag && (n_flag == v_flag);
            COND_LE: pass = z_flag || (n_flag != v_flag);
            COND_AL: pass = 1'b1;
            default: pass = 1'b0;   // never
        endcase
    end

    // Classify the instruction by its major group and sub-patterns
    always_comb
    begin
        case (instruction_word[27:26])
            GRP_DATA:
            begin
                if ((instruction_word & MUL_MASK) == MUL_MATCH)
                    cls = CLS_MUL;
                else if ((instruction_word & SWP_MASK) == SWP_MATCH)
                    cls = CLS_SWAP;
                else
                    cls = CLS_ALU;
            end
            GRP_XFER:
                cls = CLS_LDR_STR;
            GRP_BLK:
                cls = instruction_word[BIT_I] ? CLS_BRANCH : CLS_LDM_STM;
            default:
            begin
                if ((instruction_word & SWI_MASK) == SWI_MASK)
                    cls = CLS_SWI;
                else if (!instruction_word[BIT_I])
                    cls = CLS_CP_XFER;
                else if (instruction_word[BIT_CPREG])
                    cls = CLS_CP_REG;
                else
                    cls = CLS_CP_DATA;
            end
        endcase
    end

    assign dec.cond_pass = pass;
    assign dec.iclass    = cls;

endmodule

`default_nettype wire

@@ src/afd_decide.sv @@
// Priority decision: wait, interrupts, abort, breakpoint, condition, execute.
`default_nettype none

module afd_decide
    import afd_pkg::*;
(
    input  wire item_t   item,
    input  wire decode_t dec,
    input  wire logic    breakpoint_as_swi,
    output result_t      res
);

    logic fiq_take;
    logic irq_take;

    assign fiq_take = !item.interrupt_masks[FIQ_BIT] && item.interrupt_pins[FIQ_BIT];
    assign irq_take = !item.interrupt_masks[IRQ_BIT] && item.interrupt_pins[IRQ_BIT];

    // Walk the checks in priority order
    always_comb
    begin
        res.outcome            = OUT_EXECUTE;
        res.iclass             = CLS_MUL;
        res.fetch_address      = item.program_counter + PC_STEP;
        res.vector_address     = VEC_NONE;
        res.mode_after         = item.current_mode;
        res.masks_after        = item.interrupt_masks;
        res.clear_irq_and_wait = 1'b0;

        if (item.waiting && (item.interrupt_pins == 2'b00))
        begin
            // hold the PC while halted
            res.outcome       = OUT_WAIT;
            res.fetch_address = item.program_counter;
        end
        else if (fiq_take)
        begin
            res.outcome        = OUT_FIQ;
            res.vector_address = VEC_FIQ;
            res.mode_after     = FIQ_MODE;
            res.masks_after    = MASKS_ALL;
        end
        else if (irq_take)
        begin
            res.outcome            = OUT_IRQ;
            res.vector_address     = VEC_IRQ;
            res.mode_after         = IRQ_MODE;
            res.masks_after        = item.interrupt_masks;
            res.masks_after[IRQ_BIT] = 1'b1;
            res.clear_irq_and_wait = 1'b1;
        end
        else if (!item.page_mapped)
        begin
            res.outcome = OUT_PABORT;
        end
        else if (item.breakpoint_hit)
        begin
            res.outcome = breakpoint_as_swi ? OUT_BKPT_SWI : OUT_BKPT_STOP;
        end
        else if (!dec.cond_pass)
        begin
            res.outcome = OUT_COND_FAIL;
        end
        else
        begin
            res.outcome = OUT_EXECUTE;
            res.iclass  = dec.iclass;
        end
    end

endmodule

`default_nettype wire

@@ src/arm_fetch_dispatch_decision.sv @@
// Top level of the ARMv2 fetch dispatch decision block.
//
// Takes one item per clock while in_stall is low. Each item is captured in
// an input register, decoded and prioritized by short combinational logic,
// and captured in a result register. Both registers advance independently,
// so a new item is taken while a finished result waits for the sink;
// in_stall rises only when both registers are full and out_stall is high.
// The breakpoint_as_swi register (cfg_we/cfg_wdata) resets to 0; the user
// must write it only while the block is idle; the block does not enforce it.
`default_nettype none

module arm_fetch_dispatch_decision
    import afd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // configuration
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,

    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [PC_W-1:0]    program_counter,
    input  wire logic [WORD_W-1:0]  instruction_word,
    input  wire logic [FLAGS_W-1:0] nzcv_flags,
    input  wire logic [1:0]         interrupt_masks,
    input  wire logic [1:0]         interrupt_pins,
    input  wire logic [1:0]         current_mode,
    input  wire logic               waiting,
    input  wire logic               page_mapped,
    input  wire logic               breakpoint_hit,

    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              outcome,
    output logic [3:0]              instruction_class,
    output logic [PC_W-1:0]         fetch_address,
    output logic [VEC_W-1:0]        vector_address,
    output logic [1:0]              mode_after,
    output logic [1:0]              masks_after,
    output logic                    clear_irq_and_wait
);

    logic    bkpt_swi_reg;
    logic    in_vld_reg;
    logic    in_vld_next;
    item_t   in_item_reg;
    item_t   in_item_next;
    logic    res_vld_reg;
    logic    res_vld_next;
    result_t res_reg;
    result_t res_next;
    logic    res_load;
    logic    in_load;
    decode_t dec;
    result_t res_comb;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bkpt_swi_reg <= 1'b0;
        else if (cfg_we)
            bkpt_swi_reg <= cfg_wdata;
    end

    // Stage enables: result register frees when empty or taken
    assign res_load = !res_vld_reg || !out_stall;
    assign in_load  = !in_vld_reg || res_load;
    assign in_stall = !in_load;

    // Input register
    always_comb
    begin
        in_vld_next  = in_load ? in_valid : in_vld_reg;
        in_item_next = in_item_reg;
        if (in_load && in_valid)
        begin
            in_item_next.program_counter  = program_counter;
            in_item_next.instruction_word = instruction_word;
            in_item_next.nzcv_flags       = nzcv_flags;
            in_item_next.interrupt_masks  = interrupt_masks;
            in_item_next.interrupt_pins   = interrupt_pins;
            in_item_next.current_mode     = current_mode;
            in_item_next.waiting          = waiting;
            in_item_next.page_mapped      = page_mapped;
            in_item_next.breakpoint_hit   = breakpoint_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    // Decode and decide
    afd_decode u_decode (
        .instruction_word (in_item_reg.instruction_word),
        .nzcv_flags       (in_item_reg.nzcv_flags),
        .dec              (dec)
    );

    afd_decide u_decide (
        .item              (in_item_reg),
        .dec               (dec),
        .breakpoint_as_swi (bkpt_swi_reg),
        .res               (res_comb)
    );

    // Result register
    always_comb
    begin
        res_vld_next = res_load ? in_vld_reg : res_vld_reg;
        res_next     = (res_load && in_vld_reg) ? res_comb : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else
            res_vld_reg <= res_vld_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Drive the output channel
    assign out_valid          = res_vld_reg;
    assign outcome            = res_reg.outcome;
    assign instruction_class  = res_reg.iclass;
    assign fetch_address      = res_reg.fetch_address;
    assign vector_address     = res_reg.vector_address;
    assign mode_after         = res_reg.mode_after;
    assign masks_after        = res_reg.masks_after;
    assign clear_irq_and_wait = res_reg.clear_irq_and_wait;

endmodule

`default_nettype wire

@@ src/afd_checker.sv @@
// Port-level checks for the fetch dispatch decision block, with its bind.
`default_nettype none

module afd_checker
    import afd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [2:0]         outcome,
    input wire logic [3:0]         instruction_class,
    input wire logic [PC_W-1:0]    fetch_address,
    input wire logic [VEC_W-1:0]   vector_address,
    input wire logic [1:0]         mode_after,
    input wire logic [1:0]         masks_after,
    input wire logic               clear_irq_and_wait
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(outcome)
            && $stable(fetch_address) && $stable(instruction_class))
        else $error("stalled result changed");

    // Class is only reported for executed instructions
    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome != OUT_EXECUTE) |-> instruction_class == CLS_MUL)
        else $error("class set without execute");

    // FIQ entry sets vector, mode and both masks
    a_fiq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_FIQ) |-> (vector_address == VEC_FIQ)
            && (mode_after == FIQ_MODE) && (masks_after == MASKS_ALL)
            && !clear_irq_and_wait)
        else $error("bad FIQ entry");

    // Latch clear comes with IRQ entry and nothing else
    a_irq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clear_irq_and_wait |-> (outcome == OUT_IRQ)
            && (vector_address == VEC_IRQ) && (mode_after == IRQ_MODE)
            && masks_after[IRQ_BIT])
        else $error("latch clear outside IRQ entry");

    // Input is never stalled while the result register is free
    a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with free result register");

endmodule

bind arm_fetch_dispatch_decision afd_checker u_afd_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .outcome            (outcome),
    .instruction_class  (instruction_class),
    .fetch_address      (fetch_address),
    .vector_address     (vector_address),
    .mode_after         (mode_after),
    .masks_after        (masks_after),
    .clear_irq_and_wait (clear_irq_and_wait)
);

`default_nettype wire
